FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level module of the exchange enhancement unit.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MPBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MPBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mpbe_pkg.sv
// Package of the exchange enhancement unit: fixed-point type, constants,
// register indexes and helper functions (saturating add and subtract, magnitude). Depends on nothing.
package mpbe_pkg;

  localparam int IFB = 40;

  typedef logic signed [63:0] fx_t;
  typedef logic [62:0] fx_mag_t;

  localparam fx_t LIM  = 64'sh4000_0000_0000_0000;
  localparam fx_t NLIM = -64'sh4000_0000_0000_0000;
  localparam fx_t ONE  = fx_t'(64'd1 << IFB);
  localparam fx_t TWO  = fx_t'(64'd2 << IFB);
  localparam fx_t SIX  = fx_t'(64'd6 << IFB);

  typedef enum logic [1:0] {
    REG_COEF_A,
    REG_COEF_C1,
    REG_COEF_C2,
    REG_GRAD_SCALE
  } cfg_idx_t;

  localparam logic [30:0] COEF_A_RST     = 31'd42144367;
  localparam logic [31:0] COEF_C1_RST    = 32'd58924267;
  localparam logic [31:0] COEF_C2_RST    = 32'hFFC2_8F5C;
  localparam logic [30:0] GRAD_SCALE_RST = 31'd34434429;

  localparam int MUL_LAT   = 4;
  localparam int DIV_STEPS = 63;
  localparam int DIV_PER   = 4;
  localparam int DIV_NST   = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int DIV_LAT   = DIV_NST + 2;

  // Sum with two's complement wrap, then clamped to the internal range.
  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    fx_t s;
    s = a + b;
    if (s > LIM) begin
      return LIM;
    end else if (s < NLIM) begin
      return NLIM;
    end
    return s;
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    fx_t s;
    s = a - b;
    if (s > LIM) begin
      return LIM;
    end else if (s < NLIM) begin
      return NLIM;
    end
    return s;
  endfunction

  // Magnitude of a clamped value, which always fits in 63 bits.
  function automatic fx_mag_t fx_mag(input fx_t v);
    fx_t m;
    m = v[63] ? -v : v;
    return m[62:0];
  endfunction

endpackage

FILE: rtl/mpbe_exchange_enhancement_unit.sv
// Top level of the modified-PBE exchange enhancement unit: configuration
// registers, schedule, delay lines and output rounding. Depends on mpbe_pkg,
// mpbe_fmul, mpbe_fdiv and assert_macros.svh.
//
// The unit accepts one transaction every clock cycle (busy stays low) and
// returns its four results on the out_ ports for exactly one cycle, marked
// by out_valid; the receiver must take them then. The delay to the results is
// set by the chain of three dividers that form the second derivative, plus
// the multipliers around them. There is no start-up pass after reset.
`include "assert_macros.svh"

module mpbe_exchange_enhancement_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_grad_x,
  output logic               out_valid,
  output logic signed [31:0] out_enhancement,
  output logic signed [31:0] out_first_deriv,
  output logic signed [31:0] out_limit_deriv,
  output logic signed [31:0] out_second_deriv,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int LM     = mpbe_pkg::MUL_LAT;
  localparam int LD     = mpbe_pkg::DIV_LAT;
  localparam int SH_IN  = mpbe_pkg::IFB - FRAC_BITS;
  localparam int SH_OUT = mpbe_pkg::IFB - FRAC_BITS;
  localparam logic [63:0] RND_OUT = (64'd1 << SH_OUT) >> 1;

  localparam int T_S    = LM;
  localparam int T_S2X  = T_S + 1;
  localparam int T_S2   = 2 * LM;
  localparam int T_AS2  = 3 * LM;
  localparam int T_F1   = T_AS2 + 1;
  localparam int T_NUM  = T_AS2 + LM + 1;
  localparam int T_F0   = T_F1 + LD;
  localparam int T_N1   = T_NUM + LD;
  localparam int T_DF0  = T_F0 + LD;
  localparam int T_N2   = T_N1 + LD;
  localparam int T_D2F0 = T_N2 + LD;
  localparam int T_C2F0 = T_F0 + LM;
  localparam int T_Q    = T_C2F0 + LM;
  localparam int T_F    = T_Q + 2;
  localparam int T_G    = T_C2F0 + 2;
  localparam int T_SCG  = T_G + LM;
  localparam int T_DFDX = T_DF0 + LM;
  localparam int T_Q2   = T_DF0 + 2 * LM;
  localparam int T_GD   = T_D2F0 + LM;
  localparam int T_D2   = T_GD + 1 + LM;
  localparam int T_OUT  = T_D2 + 1;

  localparam int S2_DLY   = T_F1 - T_S2;
  localparam int S2X_DLY  = T_F1 - T_S2X;
  localparam int F1_DLY   = T_N2 - T_F1;
  localparam int SCG_DLY  = T_DF0 - T_SCG;
  localparam int G_DLY    = T_D2F0 - T_G;
  localparam int Q2_DLY   = T_GD - T_Q2;
  localparam int F_DLY    = T_D2 - T_F;
  localparam int DFDX_DLY = T_D2 - T_DFDX;

  typedef mpbe_pkg::fx_t fx_t;

  // Configuration registers.
  logic [30:0] coef_a_r;
  logic [31:0] coef_c1_r;
  logic [31:0] coef_c2_r;
  logic [30:0] grad_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= mpbe_pkg::COEF_A_RST;
      coef_c1_r    <= mpbe_pkg::COEF_C1_RST;
      coef_c2_r    <= mpbe_pkg::COEF_C2_RST;
      grad_scale_r <= mpbe_pkg::GRAD_SCALE_RST;
    end else if (cfg_we) begin
      unique case (mpbe_pkg::cfg_idx_t'(cfg_index))
        mpbe_pkg::REG_COEF_A: begin
          coef_a_r <= cfg_wdata[30:0];
        end
        mpbe_pkg::REG_COEF_C1: begin
          coef_c1_r <= cfg_wdata;
        end
        mpbe_pkg::REG_COEF_C2: begin
          coef_c2_r <= cfg_wdata;
        end
        mpbe_pkg::REG_GRAD_SCALE: begin
          grad_scale_r <= cfg_wdata[30:0];
        end
      endcase
    end
  end

  fx_t a_fx, c1_fx, c2_fx, sc_fx;
  fx_t c2x2_r;

  assign a_fx  = fx_t'({33'd0, coef_a_r}) << SH_IN;
  assign sc_fx = fx_t'({33'd0, grad_scale_r}) << SH_IN;
  assign c1_fx = fx_t'({{32{coef_c1_r[31]}}, coef_c1_r}) << SH_IN;
  assign c2_fx = fx_t'({{32{coef_c2_r[31]}}, coef_c2_r}) << SH_IN;

  always_ff @(posedge clk) begin
    c2x2_r <= mpbe_pkg::fx_add(c2_fx, c2_fx);
  end

  // Input stage and valid line.
  logic [T_OUT:0] vld_r;
  fx_t            x_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T_OUT-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    x_r <= fx_t'({16'd0, in_grad_x, 16'd0});
  end

  // Datapath.
  fx_t s, s2, as2, m6, c1f0, c2f0, q, scg, dfdx, q1, q2, gd, d2, sc2, ld;
  fx_t f0, t1, n1, df0, n2, d2f0;
  fx_t s2x_r, f1_r, num_r, fs_r, f_r, g2_r, g_r, inner_r;
  fx_t s2_dl   [1:S2_DLY];
  fx_t s2x_dl  [1:S2X_DLY];
  fx_t f1_dl   [1:F1_DLY];
  fx_t f0_dl   [1:LM];
  fx_t c1f0_dl [1:LM];
  fx_t scg_dl  [1:SCG_DLY];
  fx_t g_dl    [1:G_DLY];
  fx_t df0_dl  [1:LM];
  fx_t q2_dl   [1:Q2_DLY];
  fx_t f_dl    [1:F_DLY];
  fx_t dfdx_dl [1:DFDX_DLY];

  mpbe_fmul u_m_s    (.clk(clk), .a_i(sc_fx),           .b_i(x_r),           .p_o(s));
  mpbe_fmul u_m_s2   (.clk(clk), .a_i(s),               .b_i(s),             .p_o(s2));
  mpbe_fmul u_m_as2  (.clk(clk), .a_i(a_fx),            .b_i(s2),            .p_o(as2));
  mpbe_fmul u_m_m6   (.clk(clk), .a_i(mpbe_pkg::SIX),   .b_i(as2),           .p_o(m6));
  mpbe_fmul u_m_c1f0 (.clk(clk), .a_i(c1_fx),           .b_i(f0),            .p_o(c1f0));
  mpbe_fmul u_m_c2f0 (.clk(clk), .a_i(c2_fx),           .b_i(f0),            .p_o(c2f0));
  mpbe_fmul u_m_q    (.clk(clk), .a_i(c2f0),            .b_i(f0_dl[LM]),     .p_o(q));
  mpbe_fmul u_m_scg  (.clk(clk), .a_i(sc_fx),           .b_i(g_r),           .p_o(scg));
  mpbe_fmul u_m_dfdx (.clk(clk), .a_i(scg_dl[SCG_DLY]), .b_i(df0),           .p_o(dfdx));
  mpbe_fmul u_m_q1   (.clk(clk), .a_i(c2x2_r),          .b_i(df0),           .p_o(q1));
  mpbe_fmul u_m_q2   (.clk(clk), .a_i(q1),              .b_i(df0_dl[LM]),    .p_o(q2));
  mpbe_fmul u_m_gd   (.clk(clk), .a_i(g_dl[G_DLY]),     .b_i(d2f0),          .p_o(gd));
  mpbe_fmul u_m_d2   (.clk(clk), .a_i(sc2),             .b_i(inner_r),       .p_o(d2));
  mpbe_fmul u_m_sc2  (.clk(clk), .a_i(sc_fx),           .b_i(sc_fx),         .p_o(sc2));
  mpbe_fmul u_m_ld   (.clk(clk), .a_i(sc2),             .b_i(c1_fx),         .p_o(ld));

  mpbe_fdiv u_d_f0  (.clk(clk), .n_i(s2_dl[S2_DLY]),   .d_i(f1_r),               .q_o(f0));
  mpbe_fdiv u_d_t1  (.clk(clk), .n_i(s2x_dl[S2X_DLY]), .d_i(f1_r),               .q_o(t1));
  mpbe_fdiv u_d_n1  (.clk(clk), .n_i(num_r),  .d_i(f1_dl[T_NUM - T_F1]), .q_o(n1));
  mpbe_fdiv u_d_df0 (.clk(clk), .n_i(t1),     .d_i(f1_dl[T_F0 - T_F1]),  .q_o(df0));
  mpbe_fdiv u_d_n2  (.clk(clk), .n_i(n1),     .d_i(f1_dl[T_N1 - T_F1]),  .q_o(n2));
  mpbe_fdiv u_d_n3  (.clk(clk), .n_i(n2),     .d_i(f1_dl[F1_DLY]),       .q_o(d2f0));

  always_ff @(posedge clk) begin
    s2x_r   <= mpbe_pkg::fx_add(s, s);
    f1_r    <= mpbe_pkg::fx_add(mpbe_pkg::ONE, as2);
    num_r   <= mpbe_pkg::fx_sub(mpbe_pkg::TWO, m6);
    fs_r    <= mpbe_pkg::fx_add(c1f0_dl[LM], q);
    f_r     <= mpbe_pkg::fx_add(mpbe_pkg::ONE, fs_r);
    g2_r    <= mpbe_pkg::fx_add(c2f0, c2f0);
    g_r     <= mpbe_pkg::fx_add(c1_fx, g2_r);
    inner_r <= mpbe_pkg::fx_add(gd, q2_dl[Q2_DLY]);
  end

  always_ff @(posedge clk) begin
    s2_dl[1]   <= s2;
    s2x_dl[1]  <= s2x_r;
    f1_dl[1]   <= f1_r;
    f0_dl[1]   <= f0;
    c1f0_dl[1] <= c1f0;
    scg_dl[1]  <= scg;
    g_dl[1]    <= g_r;
    df0_dl[1]  <= df0;
    q2_dl[1]   <= q2;
    f_dl[1]    <= f_r;
    dfdx_dl[1] <= dfdx;
    for (int i = 2; i <= S2_DLY; i++) s2_dl[i] <= s2_dl[i-1];
    for (int i = 2; i <= S2X_DLY; i++) s2x_dl[i] <= s2x_dl[i-1];
    for (int i = 2; i <= F1_DLY; i++) f1_dl[i] <= f1_dl[i-1];
    for (int i = 2; i <= LM; i++) f0_dl[i] <= f0_dl[i-1];
    for (int i = 2; i <= LM; i++) c1f0_dl[i] <= c1f0_dl[i-1];
    for (int i = 2; i <= SCG_DLY; i++) scg_dl[i] <= scg_dl[i-1];
    for (int i = 2; i <= G_DLY; i++) g_dl[i] <= g_dl[i-1];
    for (int i = 2; i <= LM; i++) df0_dl[i] <= df0_dl[i-1];
    for (int i = 2; i <= Q2_DLY; i++) q2_dl[i] <= q2_dl[i-1];
    for (int i = 2; i <= F_DLY; i++) f_dl[i] <= f_dl[i-1];
    for (int i = 2; i <= DFDX_DLY; i++) dfdx_dl[i] <= dfdx_dl[i-1];
  end

  // Output rounding, ties away from zero, then saturation to 32 bits.
  function automatic logic [31:0] to_out(input fx_t v);
    logic [63:0] m;
    logic [63:0] mr;
    m  = {1'b0, mpbe_pkg::fx_mag(v)};
    mr = (m + RND_OUT) >> SH_OUT;
    if (v[63]) begin
      if (mr > 64'h8000_0000) begin
        return 32'h8000_0000;
      end
      return 32'(-mr);
    end
    if (mr > 64'h7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return mr[31:0];
  endfunction

  logic [31:0] enh_r, fd_r, ld_r, sd_r;

  always_ff @(posedge clk) begin
    enh_r <= to_out(f_dl[F_DLY]);
    fd_r  <= to_out(dfdx_dl[DFDX_DLY]);
    ld_r  <= to_out(ld);
    sd_r  <= to_out(d2);
  end

  assign out_valid        = vld_r[T_OUT];
  assign out_enhancement  = enh_r;
  assign out_first_deriv  = fd_r;
  assign out_limit_deriv  = ld_r;
  assign out_second_deriv = sd_r;

  `MPBE_ASSERT(a_f1_floor, vld_r[T_F1] |-> (f1_r >= mpbe_pkg::ONE), "divisor below one")
  `MPBE_ASSERT(a_f0_sign, vld_r[T_F0] |-> (f0 >= 0), "negative f0 from divider")
  `MPBE_ASSERT(a_num_max, vld_r[T_NUM] |-> (num_r <= mpbe_pkg::TWO), "numerator above two")
  `MPBE_ASSERT_ALWAYS(a_rst_quiet, $past(!rst_n) |-> !out_valid, "result strobe after reset")

endmodule

FILE: rtl/mpbe_fmul.sv
// Four-stage pipelined fixed-point multiplier with rounding and saturation.
// Built from four partial products of 32-bit and 31-bit operand halves; depends on mpbe_pkg.
module mpbe_fmul (
  input  logic             clk,
  input  mpbe_pkg::fx_t    a_i,
  input  mpbe_pkg::fx_t    b_i,
  output mpbe_pkg::fx_t    p_o
);

  localparam logic [126:0] RND = 127'd1 << (mpbe_pkg::IFB - 1);

  mpbe_pkg::fx_mag_t ma_r, mb_r;
  logic              neg_a_r, neg_b_r, neg_c_r;
  logic [63:0]       pp_ll_r;
  logic [62:0]       pp_lh_r, pp_hl_r;
  logic [61:0]       pp_hh_r;
  logic [126:0]      sum_r;
  logic [126:0]      sum_nxt;
  logic [86:0]       quo;
  mpbe_pkg::fx_t     mag_sat;
  mpbe_pkg::fx_t     p_r;

  always_ff @(posedge clk) begin
    ma_r    <= mpbe_pkg::fx_mag(a_i);
    mb_r    <= mpbe_pkg::fx_mag(b_i);
    neg_a_r <= a_i[63] ^ b_i[63];
    pp_ll_r <= {32'd0, ma_r[31:0]} * {32'd0, mb_r[31:0]};
    pp_lh_r <= {31'd0, ma_r[31:0]} * {32'd0, mb_r[62:32]};
    pp_hl_r <= {32'd0, ma_r[62:32]} * {31'd0, mb_r[31:0]};
    pp_hh_r <= {31'd0, ma_r[62:32]} * {31'd0, mb_r[62:32]};
    neg_b_r <= neg_a_r;
    sum_r   <= sum_nxt;
    neg_c_r <= neg_b_r;
    p_r     <= neg_c_r ? -mag_sat : mag_sat;
  end

  always_comb begin
    sum_nxt = {1'b0, pp_hh_r, 64'd0} + {32'd0, pp_lh_r, 32'd0}
            + {32'd0, pp_hl_r, 32'd0} + {63'd0, pp_ll_r} + RND;
  end

  always_comb begin
    quo = sum_r[126:mpbe_pkg::IFB];
    if (quo > {23'd0, mpbe_pkg::LIM}) begin
      mag_sat = mpbe_pkg::LIM;
    end else begin
      mag_sat = mpbe_pkg::fx_t'(quo[63:0]);
    end
  end

  assign p_o = p_r;

endmodule

FILE: rtl/mpbe_fdiv.sv
// Pipelined restoring divider for the fixed-point quotient n / d, d at least one.
// Several quotient bits per stage, truncation toward zero; depends on mpbe_pkg.
module mpbe_fdiv (
  input  logic             clk,
  input  mpbe_pkg::fx_t    n_i,
  input  mpbe_pkg::fx_t    d_i,
  output mpbe_pkg::fx_t    q_o
);

  localparam int NST = mpbe_pkg::DIV_NST;
  localparam int PER = mpbe_pkg::DIV_PER;
  localparam int STP = mpbe_pkg::DIV_STEPS;
  localparam int PRE = 63 - mpbe_pkg::IFB;

  logic [63:0]       rem_r  [0:NST];
  logic [62:0]       bits_r [0:NST];
  logic [62:0]       quo_r  [0:NST];
  logic [62:0]       ud_r   [0:NST];
  logic              neg_r  [0:NST];
  mpbe_pkg::fx_mag_t un;
  mpbe_pkg::fx_t     q_r;

  assign un = mpbe_pkg::fx_mag(n_i);

  always_ff @(posedge clk) begin
    rem_r[0]  <= {{(64 - mpbe_pkg::IFB){1'b0}}, un[62:PRE]};
    bits_r[0] <= {un[PRE-1:0], {mpbe_pkg::IFB{1'b0}}};
    quo_r[0]  <= '0;
    ud_r[0]   <= d_i[62:0];
    neg_r[0]  <= n_i[63];
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [63:0] rem_nxt;
    logic [62:0] bits_nxt;
    logic [62:0] quo_nxt;

    always_comb begin
      logic [63:0] r;
      logic [62:0] bt;
      logic [62:0] q;
      logic        ge;
      r  = rem_r[k];
      bt = bits_r[k];
      q  = quo_r[k];
      for (int j = 0; j < PER; j++) begin
        if (k * PER + j < STP) begin
          r  = {r[62:0], bt[62]};
          bt = {bt[61:0], 1'b0};
          ge = (r >= {1'b0, ud_r[k]});
          if (ge) begin
            r = r - {1'b0, ud_r[k]};
          end
          q = {q[61:0], ge};
        end
      end
      rem_nxt  = r;
      bits_nxt = bt;
      quo_nxt  = q;
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      bits_r[k+1] <= bits_nxt;
      quo_r[k+1]  <= quo_nxt;
      ud_r[k+1]   <= ud_r[k];
      neg_r[k+1]  <= neg_r[k];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= neg_r[NST] ? -mpbe_pkg::fx_t'({1'b0, quo_r[NST]})
                      : mpbe_pkg::fx_t'({1'b0, quo_r[NST]});
  end

  assign q_o = q_r;

endmodule
